// ===== rtl/agpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agpm_pkg
// Shared types and constants for the adaptive gain pcm mixer.
// ----------------------------------------------------------------------------
package agpm_pkg;

    localparam int SAMPLE_W         = 16;
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int FRAC_BITS        = 16;
    localparam int GAIN_W           = FRAC_BITS + 1;
    localparam int QUO_W            = FRAC_BITS;
    localparam int SHIFT_W          = 4;
    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;

    localparam logic [GAIN_W-1:0]  GAIN_UNITY  = GAIN_W'(1 << FRAC_BITS);
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(5);

    // register index, taken from paddr[2]
    localparam logic REG_RECOVERY_SHIFT = 1'b0;

    typedef struct packed {
        logic              start;
        logic [GAIN_W-1:0] rem_init;
        logic [GAIN_W-1:0] divisor;
    } agpm_div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quotient;
    } agpm_div_rsp_t;

endpackage

// ===== rtl/agpm_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agpm_divider
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module agpm_divider
    import agpm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  agpm_div_req_t req,
    output agpm_div_rsp_t rsp
);

    localparam int CNT_W = $clog2(QUO_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [GAIN_W-1:0] rem_reg;
    logic [GAIN_W-1:0] divisor_reg;
    logic [QUO_W-1:0]  quo_reg;

    logic [GAIN_W:0]   shifted;
    logic [GAIN_W:0]   diff;
    logic              fits;

    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, divisor_reg};
    assign fits    = ~diff[GAIN_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + CNT_W'(1);
                if (count_reg == CNT_W'(QUO_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // partial remainder and quotient
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= req.rem_init;
            divisor_reg <= req.divisor;
            quo_reg     <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[GAIN_W-1:0] : shifted[GAIN_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/agpm_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agpm_regs
// APB register file holding the gain recovery shift.
// ----------------------------------------------------------------------------
module agpm_regs
    import agpm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [SHIFT_W-1:0]    recovery_shift
);

    logic [SHIFT_W-1:0] shift_reg;
    logic               wr_en;
    logic               sel_shift;

    assign pready    = 1'b1;
    assign sel_shift = (paddr[2] == REG_RECOVERY_SHIFT);
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= SHIFT_RESET;
        end
        else if (wr_en && sel_shift)
        begin
            shift_reg <= pwdata[SHIFT_W-1:0];
        end
    end

    assign prdata         = sel_shift ? APB_DATA_W'(shift_reg) : '0;
    assign recovery_shift = shift_reg;

endmodule

// ===== rtl/adaptive_gain_pcm_mixer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_gain_pcm_mixer_unit
// Two-stream pcm mixer with adaptive attenuation gain and saturation.
// flow: beat summed on accept, times gain in ST_MUL, scaled and saturated in
// ST_SCALE; on saturation the 16-step divider finds the new gain in ST_DIV;
// ST_UPD recovers gain, ST_DONE loads output; only ST_IDLE takes a new beat
// the output register frees the input side while a result waits
// reset: gain returns to unity, recovery shift to 5, no beat pending
// ----------------------------------------------------------------------------
module adaptive_gain_pcm_mixer_unit
    import agpm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_ADDR_W-1:0]      paddr,
    input  logic [APB_DATA_W-1:0]      pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample_a,
    input  logic signed [SAMPLE_W-1:0] sample_b,
    input  logic                       start_of_buffer,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] mixed_sample
);

    localparam int SUM_W  = SAMPLE_W + 1;
    localparam int PROD_W = SUM_W + GAIN_W + 1;
    localparam int SCL_W  = PROD_W - FRAC_BITS;
    localparam int CMP_W  = (SAMPLE_BITS + 1 > SCL_W) ? SAMPLE_BITS + 1 : SCL_W;

    localparam logic signed [CMP_W-1:0] LIM_MAX = CMP_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [CMP_W-1:0] LIM_MIN = CMP_W'(-(1 << (SAMPLE_BITS - 1)));
    localparam logic [CMP_W-1:0]        LIM_MIN_MAG = CMP_W'(1 << (SAMPLE_BITS - 1));
    localparam logic [PROD_W-1:0]       FRAC_MASK = PROD_W'((1 << FRAC_BITS) - 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_SCALE = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_UPD   = 6'b010000,
        ST_DONE  = 6'b100000
    } agpm_state_t;

    agpm_state_t              state_reg;
    agpm_state_t              state_next;
    logic [GAIN_W-1:0]        gain_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [SAMPLE_W-1:0]      result_reg;
    logic [SAMPLE_W-1:0]      mixed_reg;
    logic                     out_valid_reg;

    logic [SHIFT_W-1:0]       recovery_shift;
    agpm_div_req_t            div_req;
    agpm_div_rsp_t            div_rsp;

    logic                     in_fire;
    logic                     out_load;
    logic [PROD_W-1:0]        prod_adj;
    logic signed [SCL_W-1:0]  scaled;
    logic signed [CMP_W-1:0]  scaled_ext;
    logic [SCL_W-1:0]         scaled_mag;
    logic                     over_hi;
    logic                     over_lo;
    logic [GAIN_W-1:0]        gain_gap;

    agpm_regs u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .recovery_shift (recovery_shift)
    );

    agpm_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // truncate toward zero
    assign prod_adj   = prod_reg + (prod_reg[PROD_W-1] ? FRAC_MASK : '0);
    assign scaled     = prod_adj[PROD_W-1 -: SCL_W];
    assign scaled_ext = CMP_W'(scaled);
    assign scaled_mag = scaled[SCL_W-1] ? SCL_W'(-scaled) : SCL_W'(scaled);
    assign over_hi    = (scaled_ext > LIM_MAX);
    assign over_lo    = (scaled_ext < LIM_MIN);
    assign gain_gap   = GAIN_UNITY - gain_reg;

    assign div_req.start    = (state_reg == ST_SCALE) && (over_hi || over_lo);
    assign div_req.rem_init = over_hi ? LIM_MAX[GAIN_W-1:0] : LIM_MIN_MAG[GAIN_W-1:0];
    assign div_req.divisor  = scaled_mag[GAIN_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                state_next = (over_hi || over_lo) ? ST_DIV : ST_UPD;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gain_reg      <= GAIN_UNITY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire && start_of_buffer)
            begin
                gain_reg <= GAIN_UNITY;
            end
            else if ((state_reg == ST_DIV) && div_rsp.done)
            begin
                gain_reg <= GAIN_W'(div_rsp.quotient);
            end
            else if ((state_reg == ST_UPD) && (gain_reg < GAIN_UNITY))
            begin
                gain_reg <= gain_reg + (gain_gap >> recovery_shift);
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // sample datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sum_reg <= SUM_W'(sample_a) + SUM_W'(sample_b);
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= sum_reg * $signed({1'b0, gain_reg});
        end
        if (state_reg == ST_SCALE)
        begin
            if (over_hi)
            begin
                result_reg <= LIM_MAX[SAMPLE_W-1:0];
            end
            else if (over_lo)
            begin
                result_reg <= LIM_MIN[SAMPLE_W-1:0];
            end
            else
            begin
                result_reg <= scaled_ext[SAMPLE_W-1:0];
            end
        end
        if (out_load)
        begin
            mixed_reg <= result_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign mixed_sample = $signed(mixed_reg);

    a_gain_max: assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg <= GAIN_UNITY)
        else $error("gain above unity");

    a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        (div_rsp.busy || div_rsp.done) |-> (state_reg == ST_DIV))
        else $error("divider active outside divide state");

    a_accept_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_MUL))
        else $error("accepted beat did not start multiply");

    a_div_gain_below_unity: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIV) && div_rsp.done) |=> (gain_reg < GAIN_UNITY))
        else $error("saturation gain not below unity");

endmodule
